// File: rtl/csvp_pkg.sv
// Shared types, constants and helper functions of the comma separated sentence parser.
package csvp_pkg;

    localparam int CSVP_FIELD_CHARS  = 20;
    localparam int CSVP_VALUE_BITS   = 32;
    localparam int CSVP_QUEUE_DEPTH  = 2;
    localparam int CSVP_NUM_VALUES   = 9;
    localparam int CSVP_HDR_LEN      = 7;
    localparam int CSVP_OUT_BITS     = 32;

    localparam logic [3:0] CSVP_HDR_FIELD   = 4'd0;
    localparam logic [3:0] CSVP_FIRST_VALUE = 4'd3;
    localparam logic [3:0] CSVP_FIELD_STOP  = 4'd15;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_NUM  = 3'b010,
        PH_STOP = 3'b100
    } t_num_phase;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic                             header_ok;
        logic signed [CSVP_OUT_BITS-1:0]  receive_ms;
        logic signed [CSVP_OUT_BITS-1:0]  intersection_number;
        logic signed [CSVP_OUT_BITS-1:0]  light_state;
        logic signed [CSVP_OUT_BITS-1:0]  countdown_value;
        logic signed [CSVP_OUT_BITS-1:0]  bus_number;
        logic signed [CSVP_OUT_BITS-1:0]  request_kind;
        logic signed [CSVP_OUT_BITS-1:0]  request_phase_value;
        logic signed [CSVP_OUT_BITS-1:0]  time_saved;
        logic signed [CSVP_OUT_BITS-1:0]  pass_allowed;
    } t_out_item;

    // Field-close command passed from the byte classifier to the value store.
    typedef struct packed {
        logic                             c1_valid;
        logic [3:0]                       c1_idx;
        logic signed [CSVP_OUT_BITS-1:0]  c1_value;
        logic                             c1_hdr_good;
        logic                             c2_valid;
        logic [3:0]                       c2_idx;
        logic                             last;
    } t_csvp_cmd;

    function automatic logic [7:0] csvp_hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h53;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h53;
            3'd6:    ch = 8'h47;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic csvp_is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: rtl/csvp_chan_if.sv
// Valid/ready channel carrying one payload item per request.
interface csvp_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/csvp_front.sv
// Byte classifier: tracks fields, matches the header and accumulates decimal values.
module csvp_front
    import csvp_pkg::*;
#(
    parameter int FIELD_CHARS = CSVP_FIELD_CHARS,
    parameter int VALUE_BITS  = CSVP_VALUE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csvp_chan_if.sink    i_in,
    csvp_chan_if.source  o_cmd
);

    localparam int CP_W  = $clog2(FIELD_CHARS + 1);
    localparam int ACC_W = VALUE_BITS + 1;
    localparam int MUL_W = ACC_W + 4;
    localparam logic [ACC_W-1:0] LIMIT = ACC_W'(1) << (VALUE_BITS - 1);

    logic [3:0]       r_fp,    n_fp;
    logic [CP_W-1:0]  r_cp,    n_cp;
    logic             r_hm,    n_hm;
    t_num_phase       r_phase, n_phase;
    logic             r_neg,   n_neg;
    logic [ACC_W-1:0] r_acc,   n_acc;

    // State of the open field after this byte has been taken.
    logic [CP_W-1:0]  t_cp;
    logic             t_hm;
    t_num_phase       t_phase;
    logic             t_neg;
    logic [ACC_W-1:0] t_acc;
    logic [3:0]       fp1;

    logic [7:0]       c;
    logic             last, active, is_zero, is_sep, is_digit, close_a, close_b, accept;
    logic [MUL_W-1:0] mul;

    logic                         src_neg, src_hm;
    logic [ACC_W-1:0]             src_acc, neg_acc;
    logic [CP_W-1:0]              src_cp;
    logic signed [VALUE_BITS-1:0] close_val;

    t_csvp_cmd cmd;

    always_comb begin
        c        = i_in.payload.msg_byte;
        last     = i_in.payload.end_of_message;
        active   = (r_fp != CSVP_FIELD_STOP);
        is_zero  = (c == CH_NUL);
        is_sep   = (c == CH_COMMA) || (c == CH_STAR);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        mul      = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + MUL_W'(c - CH_ZERO);

        t_cp    = r_cp;
        t_hm    = r_hm;
        t_phase = r_phase;
        t_neg   = r_neg;
        t_acc   = r_acc;
        if (active && !is_zero && !is_sep && (r_cp < CP_W'(FIELD_CHARS))) begin
            if ((r_cp >= CP_W'(CSVP_HDR_LEN)) || (c != csvp_hdr_char(r_cp[2:0])))
                t_hm = 1'b0;
            t_cp = r_cp + CP_W'(1);
            priority if ((r_phase == PH_SKIP) && csvp_is_blank(c)) begin
                t_phase = r_phase;
            end else if ((r_phase == PH_SKIP) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                t_neg   = (c == CH_MINUS);
                t_phase = PH_NUM;
            end else if ((r_phase != PH_STOP) && is_digit) begin
                t_acc   = (mul > MUL_W'(LIMIT)) ? LIMIT : mul[ACC_W-1:0];
                t_phase = PH_NUM;
            end else begin
                t_phase = PH_STOP;
            end
        end

        close_a = active && (is_zero || is_sep);
        if (close_a)
            fp1 = is_zero ? CSVP_FIELD_STOP : r_fp + 4'd1;
        else
            fp1 = r_fp;
        close_b = last && (fp1 != CSVP_FIELD_STOP);

        // When a separator closed a field, a close at the end is of an empty field.
        src_neg = close_a ? r_neg : t_neg;
        src_acc = close_a ? r_acc : t_acc;
        src_hm  = close_a ? r_hm  : t_hm;
        src_cp  = close_a ? r_cp  : t_cp;
        neg_acc = ACC_W'(0) - src_acc;
        if (src_neg)
            close_val = neg_acc[VALUE_BITS-1:0];
        else if (src_acc < LIMIT)
            close_val = src_acc[VALUE_BITS-1:0];
        else
            close_val = LIMIT[VALUE_BITS-1:0] - VALUE_BITS'(1);

        cmd.c1_valid    = close_a || close_b;
        cmd.c1_idx      = close_a ? r_fp : fp1;
        cmd.c1_value    = CSVP_OUT_BITS'(close_val);
        cmd.c1_hdr_good = src_hm && (src_cp == CP_W'(CSVP_HDR_LEN));
        cmd.c2_valid    = close_a && close_b;
        cmd.c2_idx      = fp1;
        cmd.last        = last;

        accept = i_in.valid && i_in.ready;

        n_fp    = r_fp;
        n_cp    = r_cp;
        n_hm    = r_hm;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (accept) begin
            if (last || close_a) begin
                n_fp    = last ? CSVP_HDR_FIELD : fp1;
                n_cp    = '0;
                n_hm    = 1'b1;
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                n_cp    = t_cp;
                n_hm    = t_hm;
                n_phase = t_phase;
                n_neg   = t_neg;
                n_acc   = t_acc;
            end
        end
    end

    assign o_cmd.valid   = i_in.valid && (close_a || last);
    assign o_cmd.payload = cmd;
    assign i_in.ready    = o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp    <= CSVP_HDR_FIELD;
            r_cp    <= '0;
            r_hm    <= 1'b1;
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_fp    <= n_fp;
            r_cp    <= n_cp;
            r_hm    <= n_hm;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

endmodule

// File: rtl/csvp_queue.sv
// Short command queue between the byte classifier and the value store.
module csvp_queue
    import csvp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    csvp_chan_if.sink    i_push,
    csvp_chan_if.source  o_pop
);

    localparam int PTR_W = (CSVP_QUEUE_DEPTH > 1) ? $clog2(CSVP_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CSVP_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CSVP_QUEUE_DEPTH - 1);

    t_csvp_cmd        r_mem [CSVP_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push, pop;

    assign i_push.ready  = (r_count != CNT_W'(CSVP_QUEUE_DEPTH));
    assign o_pop.valid   = (r_count != '0);
    assign o_pop.payload = r_mem[r_rd_ptr];

    always_comb begin
        push     = i_push.valid && i_push.ready;
        pop      = o_pop.valid && o_pop.ready;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push)
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        if (pop)
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        if (push && !pop)
            n_count = r_count + CNT_W'(1);
        else if (pop && !push)
            n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr_ptr] <= i_push.payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/csvp_back.sv
// Value store: applies field closes to the held values and registers each result.
module csvp_back
    import csvp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    csvp_chan_if.sink    i_cmd,
    csvp_chan_if.source  o_out
);

    logic                            r_hs, n_hs;
    logic signed [CSVP_OUT_BITS-1:0] r_held [CSVP_NUM_VALUES];
    logic signed [CSVP_OUT_BITS-1:0] n_held [CSVP_NUM_VALUES];
    logic                            r_out_valid, n_out_valid;
    t_out_item                       r_out, n_out;
    t_csvp_cmd                       cmd;
    logic                            pop;

    assign cmd         = i_cmd.payload;
    // A closing request may only leave the queue when the result register can take it.
    assign i_cmd.ready = !cmd.last || !r_out_valid || o_out.ready;
    assign pop         = i_cmd.valid && i_cmd.ready;

    // A new result replaces one that leaves in the same cycle.
    assign n_out_valid = (pop && cmd.last) ? 1'b1 :
                         ((o_out.valid && o_out.ready) ? 1'b0 : r_out_valid);

    always_comb begin
        n_hs   = r_hs;
        n_held = r_held;
        if (cmd.c1_valid) begin
            if (cmd.c1_idx == CSVP_HDR_FIELD) begin
                n_hs = cmd.c1_hdr_good;
                if (n_hs) begin
                    for (int k = 0; k < CSVP_NUM_VALUES; k++)
                        n_held[k] = '0;
                end
            end else if (n_hs) begin
                for (int k = 0; k < CSVP_NUM_VALUES; k++) begin
                    if (cmd.c1_idx == CSVP_FIRST_VALUE + 4'(k))
                        n_held[k] = cmd.c1_value;
                end
            end
        end
        // The second close is always of an empty field.
        if (cmd.c2_valid) begin
            if (cmd.c2_idx == CSVP_HDR_FIELD) begin
                n_hs = 1'b0;
            end else if (n_hs) begin
                for (int k = 0; k < CSVP_NUM_VALUES; k++) begin
                    if (cmd.c2_idx == CSVP_FIRST_VALUE + 4'(k))
                        n_held[k] = '0;
                end
            end
        end

        n_out.header_ok           = n_hs;
        n_out.receive_ms          = n_held[0];
        n_out.intersection_number = n_held[1];
        n_out.light_state         = n_held[2];
        n_out.countdown_value     = n_held[3];
        n_out.bus_number          = n_held[4];
        n_out.request_kind        = n_held[5];
        n_out.request_phase_value = n_held[6];
        n_out.time_saved          = n_held[7];
        n_out.pass_allowed        = n_held[8];
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (pop && cmd.last)
            r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CSVP_NUM_VALUES; k++)
                r_held[k] <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                r_hs   <= cmd.last ? 1'b0 : n_hs;
                r_held <= n_held;
            end
        end
    end

endmodule

// File: rtl/csv_sentence_field_parser.sv
// Top level of the comma separated sentence parser: one message byte per request.
// Throughput: one byte per cycle; the only stall comes from a held result on o_out.
// Path: the closing request of the final byte is written into the queue, then popped into the
// result register that drives o_out; a held result on o_out can keep it waiting in the queue.
// Reset is synchronous and active low; it clears the parse state, the queue and the held values.
module csv_sentence_field_parser
    import csvp_pkg::*;
#(
    parameter int FIELD_CHARS = CSVP_FIELD_CHARS,
    parameter int VALUE_BITS  = CSVP_VALUE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csvp_chan_if.sink    i_in,
    csvp_chan_if.source  o_out
);

    csvp_chan_if #(.t_payload(t_csvp_cmd)) w_cmd ();
    csvp_chan_if #(.t_payload(t_csvp_cmd)) w_deq ();

    csvp_front #(
        .FIELD_CHARS (FIELD_CHARS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (w_cmd)
    );

    csvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd),
        .o_pop   (w_deq)
    );

    csvp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_deq),
        .o_out   (o_out)
    );

    a_last_byte_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.payload.end_of_message
        |-> w_cmd.valid && w_cmd.ready && w_cmd.payload.last)
        else $error("final byte accepted without a closing request");

    a_empty_close_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid && w_cmd.payload.c2_valid
        |-> w_cmd.payload.last && w_cmd.payload.c1_valid)
        else $error("second field close outside the final byte");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq.valid && w_deq.ready && w_deq.payload.last |=> o_out.valid)
        else $error("closing request retired without a result");

endmodule
